// ===== rtl/ctri_pkg.sv =====
// Package for the closest ray/triangle hit core: sizes, register codes,
// queue entry and configuration types, saturation and axis helpers.
// No dependencies.
package ctri_pkg;

   localparam int MAX_TRIS   = 64;
   localparam int TRI_W      = $clog2(MAX_TRIS);
   localparam int CNT_W      = $clog2(MAX_TRIS + 1);
   localparam int ROWS       = MAX_TRIS * 3;
   localparam int ROW_AW     = $clog2(ROWS);
   localparam int ROW_W      = 96;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PW    = $clog2(FIFO_DEPTH);

   localparam logic [2:0] CSR_CAM_X       = 3'd0;
   localparam logic [2:0] CSR_CAM_Y       = 3'd1;
   localparam logic [2:0] CSR_CAM_Z       = 3'd2;
   localparam logic [2:0] CSR_FAR_LIMIT   = 3'd3;
   localparam logic [2:0] CSR_ACTIVE_TRIS = 3'd4;

   localparam logic        OP_WRITE   = 1'b0;
   localparam logic        OP_RAY     = 1'b1;
   localparam logic [1:0]  CORNER_BAD = 2'd3;

   localparam logic [30:0] FAR_RESET = 31'd6553600;

   localparam int SUM_K = 50;
   localparam int LO_K  = 49;
   localparam int HI_K  = 51;

   typedef struct packed {
      logic               op;
      logic [5:0]         slot;
      logic [1:0]         corner;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } entry_type;

   typedef struct packed {
      logic signed [31:0] cam_x;
      logic signed [31:0] cam_y;
      logic signed [31:0] cam_z;
      logic [30:0]        far_limit;
      logic [6:0]         active_tris;
   } cfg_type;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > 34'sd2147483647)        r = 32'sh7fffffff;
      else if (v < -34'sd2147483648)  r = 32'sh80000000;
      else                            r = v[31:0];
      return r;
   endfunction

   function automatic logic [1:0] axis_next(input logic [1:0] i);
      logic [1:0] r;
      unique case (i)
         2'd0:    r = 2'd1;
         2'd1:    r = 2'd2;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] axis_prev(input logic [1:0] i);
      logic [1:0] r;
      unique case (i)
         2'd0:    r = 2'd2;
         2'd1:    r = 2'd0;
         default: r = 2'd1;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/ctri_if.sv =====
// Request and response channel interfaces of the ray/triangle hit core.
// Valid/ready transfer; no dependencies.
interface ctri_req_if;
   logic               valid;
   logic               ready;
   logic               func;
   logic [5:0]         tri_slot;
   logic [1:0]         corner;
   logic signed [31:0] vert_x;
   logic signed [31:0] vert_y;
   logic signed [31:0] vert_z;
   logic signed [17:0] dir_x;
   logic signed [17:0] dir_y;
   logic signed [17:0] dir_z;

   modport source (output valid, func, tri_slot, corner, vert_x, vert_y, vert_z,
                   dir_x, dir_y, dir_z, input ready);
   modport sink   (input valid, func, tri_slot, corner, vert_x, vert_y, vert_z,
                   dir_x, dir_y, dir_z, output ready);
endinterface

interface ctri_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic [5:0]  hit_tri;
   logic [30:0] hit_dist;

   modport source (output valid, hit, hit_tri, hit_dist, input ready);
   modport sink   (input valid, hit, hit_tri, hit_dist, output ready);
endinterface

// ===== rtl/ctri_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ctri_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== rtl/ctri_front.sv =====
// Front end: accept request transfers, drop malformed writes, pack queue entries.
// Depends on ctri_pkg and ctri_req_if.
module ctri_front import ctri_pkg::*; (
   ctri_req_if.sink  req_ch,
   input  logic      full,
   output logic      push,
   output entry_type push_entry
);
   logic keep;

   assign req_ch.ready = !full;
   assign keep = (req_ch.func == OP_RAY) ||
                 ((req_ch.corner != CORNER_BAD) && (int'(req_ch.tri_slot) < MAX_TRIS));
   assign push = req_ch.valid && !full && keep;

   always_comb begin
      push_entry.op     = req_ch.func;
      push_entry.slot   = req_ch.tri_slot;
      push_entry.corner = req_ch.corner;
      if (req_ch.func == OP_RAY) begin
         push_entry.x = 32'(req_ch.dir_x);
         push_entry.y = 32'(req_ch.dir_y);
         push_entry.z = 32'(req_ch.dir_z);
      end else begin
         push_entry.x = req_ch.vert_x;
         push_entry.y = req_ch.vert_y;
         push_entry.z = req_ch.vert_z;
      end
   end
endmodule

// ===== rtl/ctri_fifo.sv =====
// Short queue between front and back end.
// Depends on ctri_pkg.
module ctri_fifo import ctri_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output entry_type head,
   output logic      head_valid
);
   entry_type          mem_ff [FIFO_DEPTH];
   logic [FIFO_PW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [FIFO_PW:0]   cnt_ff, cnt_in;

   assign full       = cnt_ff == (FIFO_PW + 1)'(FIFO_DEPTH);
   assign head_valid = cnt_ff != '0;
   assign head       = mem_ff[rp_ff];

   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (FIFO_PW + 1)'(push) - (FIFO_PW + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= push_entry;
      end
   end
endmodule

// ===== rtl/ctri_mul.sv =====
// Shared shift-add multiplier, signed 64 x 64 to 129 bits, one bit of b a cycle.
// Depends on ctri_pkg.
module ctri_mul import ctri_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [63:0]  a,
   input  logic signed [63:0]  b,
   output logic                done,
   output logic signed [128:0] prod
);
   logic                busy_ff, busy_in, done_ff, done_in, neg_ff, neg_in;
   logic [127:0]        ma_ff, ma_in, acc_ff, acc_in;
   logic [63:0]         mb_ff, mb_in;
   logic signed [128:0] prod_ff, prod_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      ma_in   = ma_ff;
      mb_in   = mb_ff;
      acc_in  = acc_ff;
      prod_in = prod_ff;
      if (start) begin
         ma_in   = 128'(a[63] ? 64'(-a) : 64'(a));
         mb_in   = b[63] ? 64'(-b) : 64'(b);
         acc_in  = '0;
         neg_in  = a[63] ^ b[63];
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (mb_ff == '0) begin
            prod_in = neg_ff ? -$signed({1'b0, acc_ff}) : $signed({1'b0, acc_ff});
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            if (mb_ff[0]) acc_in = acc_ff + ma_ff;
            ma_in = ma_ff << 1;
            mb_in = mb_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff  <= neg_in;
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
   end

   assign done = done_ff;
   assign prod = prod_ff;
endmodule

// ===== rtl/ctri_sqrt.sv =====
// Bit-serial floor square root of a 128-bit value, two radicand bits a cycle.
// Depends on ctri_pkg.
module ctri_sqrt import ctri_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [127:0] x,
   output logic         done,
   output logic [63:0]  root
);
   logic         busy_ff, busy_in, done_ff, done_in;
   logic [127:0] xs_ff, xs_in;
   logic [67:0]  rem_ff, rem_in, rem_n, trial;
   logic [63:0]  res_ff, res_in;
   logic [5:0]   cnt_ff, cnt_in;
   logic         ge;

   assign rem_n = {rem_ff[65:0], xs_ff[127:126]};
   assign trial = {2'b00, res_ff, 2'b01};
   assign ge    = rem_n >= trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      xs_in   = xs_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         xs_in   = x;
         rem_in  = '0;
         res_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? rem_n - trial : rem_n;
         res_in = {res_ff[62:0], ge};
         xs_in  = xs_ff << 2;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == '1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      xs_ff  <= xs_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign root = res_ff;
endmodule

// ===== rtl/ctri_back.sv =====
// Back end: triangle table, per-ray triangle walk and result register.
// Depends on ctri_pkg, ctri_rsp_if, ctri_ram, ctri_mul and ctri_sqrt.
module ctri_back import ctri_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  entry_type  head,
   input  logic       head_valid,
   output logic       pop,
   ctri_rsp_if.source rsp_ch
);
   typedef enum logic [4:0] {
      ST_IDLE, ST_TRI, ST_LOAD, ST_EDGE, ST_XCROSS, ST_NCHK, ST_NSHIFT, ST_DOT,
      ST_DIVCHK, ST_DIV, ST_DCHK, ST_PNT, ST_SUBV, ST_LSQ, ST_LSQRT, ST_TEST,
      ST_NEXT, ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic [CNT_W-1:0]   t_ff, t_in, count_ff, count_in;
   logic [1:0]         k_ff, k_in, lsel_ff, lsel_in;
   logic [2:0]         j_ff, j_in;
   logic [4:0]         dcnt_ff, dcnt_in;
   logic               wait_ff, wait_in, hit_ff, hit_in;
   logic signed [17:0] dir_ff [3], dir_in [3];
   logic [30:0]        lowest_ff, lowest_in, q_ff, q_in;
   logic [TRI_W-1:0]   best_ff, best_in;
   logic signed [31:0] v_ff [3][3], v_in [3][3];
   logic signed [31:0] opa_ff [3], opa_in [3], opb_ff [3], opb_in [3];
   logic signed [63:0] tmp_ff, tmp_in, num_ff, num_in, den_ff, den_in;
   logic signed [63:0] cr_ff [3], cr_in [3], n_ff [3], n_in [3];
   logic [63:0]        m_ff [3], m_in [3];
   logic               sg_ff [3], sg_in [3];
   logic signed [29:0] np_ff [3], np_in [3];
   logic [79:0]        rem_ff, rem_in, dsh_ff, dsh_in;
   logic [127:0]       sq_ff, sq_in;
   logic [63:0]        area_ff, area_in;
   logic [65:0]        ssum_ff, ssum_in;
   logic               rv_ff, rv_in, rhit_ff, rhit_in;
   logic [5:0]         rtri_ff, rtri_in;
   logic [30:0]        rdist_ff, rdist_in;

   logic                ram_we;
   logic [ROW_AW-1:0]   ram_waddr, ram_raddr;
   logic [ROW_W-1:0]    ram_wdata, ram_rdata;
   logic                mul_start, mul_done, sqrt_start, sqrt_done;
   logic signed [63:0]  mul_a, mul_b;
   logic signed [128:0] prod;
   logic [63:0]         root;

   logic signed [31:0]  cam [3];
   logic signed [31:0]  ld_rel [3];
   logic [1:0]          xi, a_idx, b_idx;
   logic [63:0]         un, ud;
   logic [79:0]         rem0, dtop;
   logic [128:0]        pm, pm_sh;
   logic signed [33:0]  p34;
   logic [71:0]         lhs, r_lo, r_hi;
   logic                big;

   ctri_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_ram (
      .clock(clock), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
      .raddr(ram_raddr), .rdata(ram_rdata)
   );

   ctri_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .a(mul_a), .b(mul_b),
      .done(mul_done), .prod(prod)
   );

   ctri_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sqrt_start), .x(sq_ff),
      .done(sqrt_done), .root(root)
   );

   assign cam[0] = cfg.cam_x;
   assign cam[1] = cfg.cam_y;
   assign cam[2] = cfg.cam_z;

   assign ram_waddr = ROW_AW'({head.slot, 1'b0}) + ROW_AW'(head.slot) + ROW_AW'(head.corner);
   assign ram_wdata = {head.z, head.y, head.x};

   assign xi    = j_ff[2:1];
   assign a_idx = j_ff[0] ? axis_prev(xi) : axis_next(xi);
   assign b_idx = j_ff[0] ? axis_next(xi) : axis_prev(xi);

   assign un   = num_ff[63] ? 64'(-num_ff) : 64'(num_ff);
   assign ud   = den_ff[63] ? 64'(-den_ff) : 64'(den_ff);
   assign rem0 = {un, 16'b0};
   assign dtop = 80'(ud) << 31;

   assign pm    = prod[128] ? $unsigned(-prod) : $unsigned(prod);
   assign pm_sh = pm >> 16;
   assign p34   = prod[128] ? -$signed({1'b0, pm_sh[32:0]}) : $signed({1'b0, pm_sh[32:0]});

   assign lhs  = 72'(ssum_ff) * 72'(SUM_K);
   assign r_lo = 72'(area_ff) * 72'(LO_K);
   assign r_hi = 72'(area_ff) * 72'(HI_K);

   always_comb begin
      big = 1'b0;
      for (int i = 0; i < 3; i++) begin
         ld_rel[i] = sat32(34'($signed(ram_rdata[32*i +: 32])) - 34'(cam[i]));
         if (m_ff[i][63:29] != '0) big = 1'b1;
      end
   end

   always_comb begin
      state_in  = state_ff;
      t_in      = t_ff;
      count_in  = count_ff;
      k_in      = k_ff;
      lsel_in   = lsel_ff;
      j_in      = j_ff;
      dcnt_in   = dcnt_ff;
      wait_in   = wait_ff;
      hit_in    = hit_ff;
      dir_in    = dir_ff;
      lowest_in = lowest_ff;
      q_in      = q_ff;
      best_in   = best_ff;
      v_in      = v_ff;
      opa_in    = opa_ff;
      opb_in    = opb_ff;
      tmp_in    = tmp_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      cr_in     = cr_ff;
      n_in      = n_ff;
      m_in      = m_ff;
      sg_in     = sg_ff;
      np_in     = np_ff;
      rem_in    = rem_ff;
      dsh_in    = dsh_ff;
      sq_in     = sq_ff;
      area_in   = area_ff;
      ssum_in   = ssum_ff;
      rv_in     = rv_ff;
      rhit_in   = rhit_ff;
      rtri_in   = rtri_ff;
      rdist_in  = rdist_ff;
      pop        = 1'b0;
      ram_we     = 1'b0;
      ram_raddr  = ROW_AW'({t_ff[TRI_W-1:0], 1'b0}) + ROW_AW'(t_ff[TRI_W-1:0]) + ROW_AW'(k_ff);
      mul_start  = 1'b0;
      mul_a      = '0;
      mul_b      = '0;
      sqrt_start = 1'b0;

      if (rv_ff && rsp_ch.ready) rv_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               pop = 1'b1;
               if (head.op == OP_WRITE) begin
                  ram_we = 1'b1;
               end else begin
                  dir_in[0] = head.x[17:0];
                  dir_in[1] = head.y[17:0];
                  dir_in[2] = head.z[17:0];
                  lowest_in = cfg.far_limit;
                  count_in  = (int'(cfg.active_tris) > MAX_TRIS) ? CNT_W'(MAX_TRIS)
                                                                 : CNT_W'(cfg.active_tris);
                  t_in      = '0;
                  hit_in    = 1'b0;
                  best_in   = '0;
                  state_in  = ST_TRI;
               end
            end
         end
         ST_TRI: begin
            k_in     = '0;
            state_in = (t_ff == count_ff) ? ST_OUT : ST_LOAD;
         end
         ST_LOAD: begin
            unique case (k_ff)
               2'd1:    v_in[0] = ld_rel;
               2'd2:    v_in[1] = ld_rel;
               2'd3:    v_in[2] = ld_rel;
               default: ;
            endcase
            k_in = k_ff + 1'b1;
            if (k_ff == 2'd3) state_in = ST_EDGE;
         end
         ST_EDGE: begin
            for (int i = 0; i < 3; i++) begin
               opa_in[i] = sat32(34'(v_ff[1][i]) - 34'(v_ff[0][i]));
               opb_in[i] = sat32(34'(v_ff[2][i]) - 34'(v_ff[0][i]));
            end
            lsel_in  = '0;
            j_in     = '0;
            wait_in  = 1'b0;
            state_in = ST_XCROSS;
         end
         ST_XCROSS: begin
            mul_a = 64'(opa_ff[a_idx]);
            mul_b = 64'(opb_ff[b_idx]);
            if (!wait_ff) begin
               mul_start = 1'b1;
               wait_in   = 1'b1;
            end else if (mul_done) begin
               wait_in = 1'b0;
               if (!j_ff[0]) tmp_in = prod[63:0];
               else          cr_in[xi] = tmp_ff - prod[63:0];
               j_in = j_ff + 1'b1;
               if (j_ff == 3'd5) begin
                  j_in  = '0;
                  sq_in = '0;
                  state_in = (lsel_ff == 2'd0) ? ST_NCHK : ST_LSQ;
               end
            end
         end
         ST_NCHK: begin
            if (cr_ff[0] == '0 && cr_ff[1] == '0 && cr_ff[2] == '0) begin
               state_in = ST_NEXT;
            end else begin
               for (int i = 0; i < 3; i++) begin
                  n_in[i]  = cr_ff[i];
                  sg_in[i] = cr_ff[i][63];
                  m_in[i]  = cr_ff[i][63] ? 64'(-cr_ff[i]) : 64'(cr_ff[i]);
               end
               state_in = ST_NSHIFT;
            end
         end
         ST_NSHIFT: begin
            if (big) begin
               for (int i = 0; i < 3; i++) m_in[i] = m_ff[i] >> 1;
            end else begin
               for (int i = 0; i < 3; i++) begin
                  np_in[i] = sg_ff[i] ? -$signed({1'b0, m_ff[i][28:0]})
                                      : $signed({1'b0, m_ff[i][28:0]});
               end
               num_in   = '0;
               den_in   = '0;
               j_in     = '0;
               wait_in  = 1'b0;
               state_in = ST_DOT;
            end
         end
         ST_DOT: begin
            mul_a = j_ff[0] ? 64'(dir_ff[xi]) : 64'(v_ff[0][xi]);
            mul_b = 64'(np_ff[xi]);
            if (!wait_ff) begin
               mul_start = 1'b1;
               wait_in   = 1'b1;
            end else if (mul_done) begin
               wait_in = 1'b0;
               if (!j_ff[0]) num_in = num_ff + prod[63:0];
               else          den_in = den_ff + prod[63:0];
               j_in = j_ff + 1'b1;
               if (j_ff == 3'd5) state_in = ST_DIVCHK;
            end
         end
         ST_DIVCHK: begin
            if (num_ff == '0 || den_ff == '0 || (num_ff[63] != den_ff[63]) || rem0 >= dtop) begin
               state_in = ST_NEXT;
            end else begin
               rem_in   = rem0;
               dsh_in   = dtop >> 1;
               dcnt_in  = 5'd30;
               q_in     = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (rem_ff >= dsh_ff) begin
               rem_in = rem_ff - dsh_ff;
               q_in   = {q_ff[29:0], 1'b1};
            end else begin
               q_in   = {q_ff[29:0], 1'b0};
            end
            dsh_in  = dsh_ff >> 1;
            dcnt_in = dcnt_ff - 1'b1;
            if (dcnt_ff == '0) state_in = ST_DCHK;
         end
         ST_DCHK: begin
            j_in    = '0;
            wait_in = 1'b0;
            state_in = (q_ff == '0 || q_ff >= lowest_ff) ? ST_NEXT : ST_PNT;
         end
         ST_PNT: begin
            mul_a = 64'($signed({1'b0, q_ff}));
            mul_b = 64'(dir_ff[j_ff[1:0]]);
            if (!wait_ff) begin
               mul_start = 1'b1;
               wait_in   = 1'b1;
            end else if (mul_done) begin
               wait_in = 1'b0;
               opa_in[j_ff[1:0]] = sat32(p34);
               j_in = j_ff + 1'b1;
               if (j_ff == 3'd2) state_in = ST_SUBV;
            end
         end
         ST_SUBV: begin
            for (int c = 0; c < 3; c++) begin
               for (int i = 0; i < 3; i++) begin
                  v_in[c][i] = sat32(34'(v_ff[c][i]) - 34'(opa_ff[i]));
               end
            end
            cr_in    = n_ff;
            lsel_in  = '0;
            j_in     = '0;
            sq_in    = '0;
            wait_in  = 1'b0;
            state_in = ST_LSQ;
         end
         ST_LSQ: begin
            mul_a = cr_ff[j_ff[1:0]];
            mul_b = cr_ff[j_ff[1:0]];
            if (!wait_ff) begin
               mul_start = 1'b1;
               wait_in   = 1'b1;
            end else if (mul_done) begin
               wait_in = 1'b0;
               sq_in   = sq_ff + prod[127:0];
               j_in    = j_ff + 1'b1;
               if (j_ff == 3'd2) state_in = ST_LSQRT;
            end
         end
         ST_LSQRT: begin
            if (!wait_ff) begin
               sqrt_start = 1'b1;
               wait_in    = 1'b1;
            end else if (sqrt_done) begin
               wait_in = 1'b0;
               if (lsel_ff == 2'd0) begin
                  area_in = root;
                  ssum_in = '0;
               end else begin
                  ssum_in = ssum_ff + 66'(root);
               end
               if (lsel_ff == 2'd3) begin
                  state_in = ST_TEST;
               end else begin
                  lsel_in = lsel_ff + 1'b1;
                  j_in    = '0;
                  unique case (lsel_ff)
                     2'd0: begin
                        opa_in = v_ff[0];
                        opb_in = v_ff[1];
                     end
                     2'd1: begin
                        opa_in = v_ff[1];
                        opb_in = v_ff[2];
                     end
                     default: begin
                        opa_in = v_ff[2];
                        opb_in = v_ff[0];
                     end
                  endcase
                  state_in = ST_XCROSS;
               end
            end
         end
         ST_TEST: begin
            if (lhs > r_lo && lhs < r_hi) begin
               lowest_in = q_ff;
               best_in   = t_ff[TRI_W-1:0];
               hit_in    = 1'b1;
            end
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            t_in     = t_ff + 1'b1;
            state_in = ST_TRI;
         end
         ST_OUT: begin
            if (!rv_ff || rsp_ch.ready) begin
               rv_in    = 1'b1;
               rhit_in  = hit_ff;
               rtri_in  = hit_ff ? 6'(best_ff) : 6'd0;
               rdist_in = lowest_ff;
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wait_ff  <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         wait_ff  <= wait_in;
         rv_ff    <= rv_in;
      end
      t_ff      <= t_in;
      count_ff  <= count_in;
      k_ff      <= k_in;
      lsel_ff   <= lsel_in;
      j_ff      <= j_in;
      dcnt_ff   <= dcnt_in;
      hit_ff    <= hit_in;
      dir_ff    <= dir_in;
      lowest_ff <= lowest_in;
      q_ff      <= q_in;
      best_ff   <= best_in;
      v_ff      <= v_in;
      opa_ff    <= opa_in;
      opb_ff    <= opb_in;
      tmp_ff    <= tmp_in;
      num_ff    <= num_in;
      den_ff    <= den_in;
      cr_ff     <= cr_in;
      n_ff      <= n_in;
      m_ff      <= m_in;
      sg_ff     <= sg_in;
      np_ff     <= np_in;
      rem_ff    <= rem_in;
      dsh_ff    <= dsh_in;
      sq_ff     <= sq_in;
      area_ff   <= area_in;
      ssum_ff   <= ssum_in;
      rhit_ff   <= rhit_in;
      rtri_ff   <= rtri_in;
      rdist_ff  <= rdist_in;
   end

   assign rsp_ch.valid    = rv_ff;
   assign rsp_ch.hit      = rhit_ff;
   assign rsp_ch.hit_tri  = rtri_ff;
   assign rsp_ch.hit_dist = rdist_ff;
endmodule

// ===== rtl/closest_ray_triangle_hit_core.sv =====
// Top level of the closest ray/triangle hit core: configuration registers,
// front end, queue and back end. Depends on ctri_pkg, ctri_if and all ctri_ modules.
//
//  channel  role    transfer
//  req_ch   sink    valid & ready; func 0 loads a corner, func 1 casts a ray
//  rsp_ch   source  valid & ready; one result per ray
//  csr_*    write   csr_wr_en; index csr_index, data csr_wdata
//
// A corner write is stored straight from the queue head. A ray walks every active
// triangle and leaves one early when it fails before the area test; the shift-add
// multiplier (one bit of its second operand a cycle) and the bit-serial square root
// set how long each triangle takes.
// Reset is synchronous; the triangle table is not cleared. Requests stall only
// when the four-entry queue is full; a waiting result does not block the queue.
module closest_ray_triangle_hit_core import ctri_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ctri_req_if.sink    req_ch,
   ctri_rsp_if.source  rsp_ch,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   cfg_type   cfg_ff, cfg_in;
   logic      push, full, pop, head_valid;
   entry_type push_entry, head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CAM_X:       cfg_in.cam_x       = csr_wdata;
            CSR_CAM_Y:       cfg_in.cam_y       = csr_wdata;
            CSR_CAM_Z:       cfg_in.cam_z       = csr_wdata;
            CSR_FAR_LIMIT:   cfg_in.far_limit   = csr_wdata[30:0];
            CSR_ACTIVE_TRIS: cfg_in.active_tris = csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cam_x       <= '0;
         cfg_ff.cam_y       <= '0;
         cfg_ff.cam_z       <= '0;
         cfg_ff.far_limit   <= FAR_RESET;
         cfg_ff.active_tris <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ctri_front u_front (
      .req_ch(req_ch), .full(full), .push(push), .push_entry(push_entry)
   );

   ctri_fifo u_fifo (
      .clock(clock), .reset(reset), .push(push), .push_entry(push_entry), .full(full),
      .pop(pop), .head(head), .head_valid(head_valid)
   );

   ctri_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .head(head), .head_valid(head_valid),
      .pop(pop), .rsp_ch(rsp_ch)
   );
endmodule

// ===== sim/tb_closest_ray_triangle_hit_core.sv =====
`timescale 1ns / 100ps
// Testbench for closest_ray_triangle_hit_core: loads triangle corners, casts rays and
// checks each hit result against a bit-exact fixed-point predictor of the nearest hit or a given expectation.
// Depends on ctri_pkg, ctri_if and the core's RTL.
module tb_closest_ray_triangle_hit_core;
   import ctri_pkg::*;

   localparam int U           = 65536;
   localparam int STALL_LIMIT = 600000;
   localparam int HOLD_CYCLES = 40000;

   typedef struct {
      logic        hit;
      logic [5:0]  slot;
      logic [30:0] hdist;
   } hit_rec_type;

   typedef enum {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic         func;
      logic [5:0]   slot;
      logic [1:0]   corner;
      int           x, y, z, dx, dy, dz;
      logic [2:0]   idx;
      logic [31:0]  data;
      bit           typed;
      hit_rec_type  want;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   ctri_req_if req_ch();
   ctri_rsp_if rsp_ch();

   closest_ray_triangle_hit_core dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // shadow of the core's table and registers
   logic [31:0] vstore [MAX_TRIS*9];
   longint      cam_m [3];
   logic [30:0] far_m;
   logic [6:0]  act_m;

   hit_rec_type hit_q[$];
   row_type     plan[$];
   int          n_err = 0;
   int          quiet_cnt = 0;
   bit          tx_calm = 0;
   bit          squeeze = 0;

   function automatic longint sat32l(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic logic [63:0] magl(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic longint shr_t(longint v, int s);
      logic [63:0] m;
      m = magl(v) >> s;
      return v < 0 ? -longint'(m) : longint'(m);
   endfunction

   function automatic void diff3(input longint a[3], input longint b[3], output longint r[3]);
      for (int i = 0; i < 3; i++) r[i] = sat32l(a[i] - b[i]);
   endfunction

   function automatic void cross3(input longint a[3], input longint b[3], output longint c[3]);
      c[0] = a[1] * b[2] - a[2] * b[1];
      c[1] = a[2] * b[0] - a[0] * b[2];
      c[2] = a[0] * b[1] - a[1] * b[0];
   endfunction

   function automatic logic [63:0] len3(input longint c[3]);
      logic [127:0] sq;
      logic [63:0]  root, cand, m;
      sq = '0;
      root = '0;
      for (int i = 0; i < 3; i++) begin
         m = magl(c[i]);
         sq += 128'(m) * 128'(m);
      end
      for (int b = 63; b >= 0; b--) begin
         cand = root | (64'd1 << b);
         if (128'(cand) * 128'(cand) <= sq) root = cand;
      end
      return root;
   endfunction

   function automatic hit_rec_type nearest_hit(int dx, int dy, int dz);
      longint      dir[3], v0[3], v1[3], v2[3], e1[3], e2[3], n[3], np[3], p[3];
      longint      ap[3], bp[3], cp[3], c1[3], c2[3], c3[3];
      longint      num, den;
      logic [63:0] mx, un, ud, q, r, d, area, lowest;
      logic [127:0] tot, lhs;
      int          s, cnt;
      hit_rec_type res;
      dir[0] = dx; dir[1] = dy; dir[2] = dz;
      res.hit = 1'b0;
      res.slot = '0;
      lowest = 64'(far_m);
      cnt = act_m > MAX_TRIS ? MAX_TRIS : int'(act_m);
      for (int t = 0; t < cnt; t++) begin
         for (int i = 0; i < 3; i++) begin
            v0[i] = sat32l(longint'($signed(vstore[t*9+i])) - cam_m[i]);
            v1[i] = sat32l(longint'($signed(vstore[t*9+3+i])) - cam_m[i]);
            v2[i] = sat32l(longint'($signed(vstore[t*9+6+i])) - cam_m[i]);
         end
         diff3(v1, v0, e1);
         diff3(v2, v0, e2);
         cross3(e1, e2, n);
         mx = '0;
         for (int i = 0; i < 3; i++) if (magl(n[i]) > mx) mx = magl(n[i]);
         if (mx == 0) continue;
         s = 0;
         while ((mx >> s) >= (64'd1 << 29)) s++;
         num = 0;
         den = 0;
         for (int i = 0; i < 3; i++) begin
            np[i] = shr_t(n[i], s);
            num += np[i] * v0[i];
            den += np[i] * dir[i];
         end
         if (den == 0 || num == 0 || ((num < 0) != (den < 0))) continue;
         un = magl(num);
         ud = magl(den);
         q = un / ud;
         if (q >= (64'd1 << 15)) continue;
         r = un % ud;
         d = (q << 16) | ((r << 16) / ud);
         if (d == 0 || d >= lowest) continue;
         for (int i = 0; i < 3; i++) p[i] = sat32l(shr_t(longint'(d) * dir[i], 16));
         diff3(v0, p, ap);
         diff3(v1, p, bp);
         diff3(v2, p, cp);
         cross3(ap, bp, c1);
         cross3(bp, cp, c2);
         cross3(cp, ap, c3);
         tot = 128'(len3(c1)) + 128'(len3(c2)) + 128'(len3(c3));
         lhs = tot * 50;
         area = len3(n);
         if (lhs > 128'(area) * 49 && lhs < 128'(area) * 51) begin
            lowest = d;
            res.hit = 1'b1;
            res.slot = t[5:0];
         end
      end
      res.hdist = lowest[30:0];
      return res;
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 20);
      return $urandom_range(50, 300);
   endfunction

   function automatic real rreal(real lo, real hi);
      return lo + (hi - lo) * real'($urandom_range(0, 1000000)) / 1.0e6;
   endfunction

   function automatic int to_fix(real v);
      if (v * 65536.0 >= 2147483647.0) return 32'h7fffffff;
      if (v * 65536.0 <= -2147483648.0) return 32'h80000000;
      return $rtoi(v * 65536.0);
   endfunction

   function automatic hit_rec_type no_hit(logic [30:0] hdist);
      hit_rec_type h;
      h.hit = 1'b0;
      h.slot = '0;
      h.hdist = hdist;
      return h;
   endfunction

   function automatic row_type item_row(logic func, logic [5:0] slot, logic [1:0] corner,
                                        int x, int y, int z, int dx, int dy, int dz);
      row_type w;
      w = '{kind: ROW_ITEM, default: 0};
      w.func = func; w.slot = slot; w.corner = corner;
      w.x = x; w.y = y; w.z = z; w.dx = dx; w.dy = dy; w.dz = dz;
      return w;
   endfunction

   function automatic row_type csr_row(logic [2:0] idx, logic [31:0] data);
      row_type w;
      w = '{kind: ROW_CSR, default: 0};
      w.idx = idx; w.data = data;
      return w;
   endfunction

   function automatic row_type ray_typed(int dx, int dy, int dz, hit_rec_type want);
      row_type w;
      w = item_row(OP_RAY, 0, 0, 0, 0, 0, dx, dy, dz);
      w.typed = 1;
      w.want = want;
      return w;
   endfunction

   task automatic send(row_type w);
      req_ch.valid = 1'b1;
      req_ch.func = w.func;
      req_ch.tri_slot = w.slot;
      req_ch.corner = w.corner;
      req_ch.vert_x = w.x; req_ch.vert_y = w.y; req_ch.vert_z = w.z;
      req_ch.dir_x = w.dx; req_ch.dir_y = w.dy; req_ch.dir_z = w.dz;
      do @(posedge clock); while (!req_ch.ready);
      if (w.func == OP_WRITE) begin
         if (w.corner != CORNER_BAD) begin
            vstore[w.slot*9 + w.corner*3]     = w.x;
            vstore[w.slot*9 + w.corner*3 + 1] = w.y;
            vstore[w.slot*9 + w.corner*3 + 2] = w.z;
         end
      end else begin
         hit_q.push_back(w.typed ? w.want : nearest_hit(w.dx, w.dy, w.dz));
      end
      @(negedge clock);
      req_ch.valid = 1'b0;
      if (!tx_calm) repeat (gap_len()) @(negedge clock);
   endtask

   task automatic wait_idle();
      while (hit_q.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [31:0] data);
      wait_idle();
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (idx)
         CSR_CAM_X:       cam_m[0] = longint'($signed(data));
         CSR_CAM_Y:       cam_m[1] = longint'($signed(data));
         CSR_CAM_Z:       cam_m[2] = longint'($signed(data));
         CSR_FAR_LIMIT:   far_m = data[30:0];
         CSR_ACTIVE_TRIS: act_m = data[6:0];
         default: ;
      endcase
   endtask

   task automatic write_tri(int slot);
      real cx, cy, cz, ux, uy, uz, len, span;
      row_type w;
      ux = rreal(-1.0, 1.0); uy = rreal(-1.0, 1.0); uz = rreal(-1.0, 1.0);
      len = $sqrt(ux*ux + uy*uy + uz*uz) + 1.0e-3;
      span = rreal(2.0, 40.0);
      cx = real'(cam_m[0]) / 65536.0 + ux / len * span;
      cy = real'(cam_m[1]) / 65536.0 + uy / len * span;
      cz = real'(cam_m[2]) / 65536.0 + uz / len * span;
      for (int k = 0; k < 3; k++) begin
         w = item_row(OP_WRITE, slot, k, to_fix(cx + rreal(-4.0, 4.0)),
                      to_fix(cy + rreal(-4.0, 4.0)), to_fix(cz + rreal(-4.0, 4.0)), 0, 0, 0);
         if ($urandom_range(0, 7) == 0) w.x = $urandom();
         if ($urandom_range(0, 7) == 0) w.y = $urandom();
         if ($urandom_range(0, 7) == 0) w.z = $urandom();
         w.dx = $urandom(); w.dy = $urandom(); w.dz = $urandom();
         send(w);
      end
      if ($urandom_range(0, 9) == 0)
         send(item_row(OP_WRITE, $urandom(), CORNER_BAD, $urandom(), $urandom(), $urandom(),
                       $urandom(), $urandom(), $urandom()));
   endtask

   task automatic cast_ray(int ntri);
      real     w0, w1, w2, px, py, pz, len;
      int      b, slot;
      row_type w;
      if ($urandom_range(0, 4) == 0) begin
         w = item_row(OP_RAY, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                      $urandom_range(0, 2*U) - U, $urandom_range(0, 2*U) - U,
                      $urandom_range(0, 2*U) - U);
      end else begin
         slot = $urandom_range(0, ntri - 1);
         b = slot * 9;
         w1 = rreal(-0.05, 1.05);
         w2 = rreal(-0.05, 1.05 - w1);
         w0 = 1.0 - w1 - w2;
         px = 0.0; py = 0.0; pz = 0.0;
         for (int k = 0; k < 3; k++) begin
            real wk;
            wk = (k == 0) ? w0 : (k == 1) ? w1 : w2;
            px += wk * (real'($signed(vstore[b+k*3]))   - real'(cam_m[0]));
            py += wk * (real'($signed(vstore[b+k*3+1])) - real'(cam_m[1]));
            pz += wk * (real'($signed(vstore[b+k*3+2])) - real'(cam_m[2]));
         end
         len = $sqrt(px*px + py*py + pz*pz);
         if (len < 1.0) len = 1.0;
         w = item_row(OP_RAY, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                      $rtoi(px / len * 65536.0), $rtoi(py / len * 65536.0),
                      $rtoi(pz / len * 65536.0));
      end
      send(w);
   endtask

   // response side: random backpressure and one long hold-off
   initial begin
      int  hold;
      bit  calm, held;
      hold = 0; calm = 0; held = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 999) == 0) calm = !calm;
         if (squeeze && !held) begin
            held = 1;
            hold = HOLD_CYCLES;
         end
         if (reset) begin
            rsp_ch.ready = 1'b0;
         end else if (hold > 0) begin
            rsp_ch.ready = 1'b0;
            hold--;
         end else begin
            rsp_ch.ready = 1'b1;
            if (!calm && $urandom_range(0, 5) == 0) hold = gap_len();
         end
      end
   end

   always @(posedge clock) begin
      hit_rec_type want;
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet_cnt = 0;
      else quiet_cnt++;
      if (quiet_cnt >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (hit_q.size() == 0) begin
            n_err++;
            if (n_err <= 10) $display("unexpected result hit=%0d tri=%0d dist=%0d",
                                      rsp_ch.hit, rsp_ch.hit_tri, rsp_ch.hit_dist);
         end else begin
            want = hit_q.pop_front();
            if (rsp_ch.hit !== want.hit || rsp_ch.hit_tri !== want.slot ||
                rsp_ch.hit_dist !== want.hdist) begin
               n_err++;
               if (n_err <= 10)
                  $display("mismatch: exp hit=%0d tri=%0d dist=%0d, got hit=%0d tri=%0d dist=%0d",
                           want.hit, want.slot, want.hdist,
                           rsp_ch.hit, rsp_ch.hit_tri, rsp_ch.hit_dist);
            end
         end
      end
   end

   initial begin
      int ntri;
      req_ch.valid = 1'b0;
      req_ch.func = OP_WRITE;
      req_ch.tri_slot = '0;
      req_ch.corner = '0;
      req_ch.vert_x = '0; req_ch.vert_y = '0; req_ch.vert_z = '0;
      req_ch.dir_x = '0; req_ch.dir_y = '0; req_ch.dir_z = '0;
      cam_m[0] = 0; cam_m[1] = 0; cam_m[2] = 0;
      far_m = FAR_RESET;
      act_m = '0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      plan.push_back(ray_typed(U, 0, 0, no_hit(FAR_RESET)));
      plan.push_back(item_row(OP_WRITE, 0, 0, -2*U, -2*U, 10*U, 0, 0, 0));
      plan.push_back(item_row(OP_WRITE, 0, 1,  2*U, -2*U, 10*U, 0, 0, 0));
      plan.push_back(item_row(OP_WRITE, 0, 2,  0,    2*U, 10*U, 0, 0, 0));
      plan.push_back(item_row(OP_WRITE, 0, CORNER_BAD, -1, -1, -1, -1, -1, -1));
      for (int k = 0; k < 3; k++) plan.push_back(item_row(OP_WRITE, 1, k, U, U, 5*U, 0, 0, 0));
      plan.push_back(item_row(OP_WRITE, 2, 0, 32'h80000000, 32'h7fffffff, 32'h80000000, 0, 0, 0));
      plan.push_back(item_row(OP_WRITE, 2, 1, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0, 0));
      plan.push_back(item_row(OP_WRITE, 2, 2, 0, 32'h7fffffff, 32'h80000000, 0, 0, 0));
      for (int s = 3; s < 5; s++) begin
         plan.push_back(item_row(OP_WRITE, s, 0, -U, -U, 5*U, 0, 0, 0));
         plan.push_back(item_row(OP_WRITE, s, 1,  U, -U, 5*U, 0, 0, 0));
         plan.push_back(item_row(OP_WRITE, s, 2,  0,  U, 5*U, 0, 0, 0));
      end
      plan.push_back(csr_row(CSR_ACTIVE_TRIS, 5));
      plan.push_back(item_row(OP_RAY, 0, 0, 0, 0, 0, 0, 0, U));
      plan.push_back(ray_typed(0, 0, 0, no_hit(FAR_RESET)));
      plan.push_back(item_row(OP_RAY, 0, 0, 0, 0, 0, -U, -U, -U));
      plan.push_back(csr_row(CSR_FAR_LIMIT, 0));
      plan.push_back(ray_typed(0, 0, U, no_hit(0)));
      plan.push_back(csr_row(CSR_FAR_LIMIT, 32'h7fffffff));
      plan.push_back(csr_row(CSR_CAM_X, 32'h80000000));
      plan.push_back(csr_row(CSR_CAM_Y, 32'h7fffffff));
      plan.push_back(item_row(OP_RAY, 0, 0, 0, 0, 0, U, -U, 0));
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) csr_write(plan[i].idx, plan[i].data);
         else send(plan[i]);
      end

      // fill the whole table, then sweep past the table size
      csr_write(CSR_CAM_X, $urandom_range(0, 16*U) - 8*U);
      csr_write(CSR_CAM_Y, $urandom_range(0, 16*U) - 8*U);
      csr_write(CSR_CAM_Z, $urandom_range(0, 16*U) - 8*U);
      for (int s = 0; s < MAX_TRIS; s++) write_tri(s);
      csr_write(CSR_ACTIVE_TRIS, 70);
      for (int k = 0; k < 2; k++) cast_ray(MAX_TRIS);

      for (int ph = 0; ph < 8; ph++) begin
         ntri = $urandom_range(1, 3);
         if (ph == 2) begin
            csr_write(CSR_CAM_X, 32'h7fffffff);
            csr_write(CSR_CAM_Y, 32'h80000000);
            csr_write(CSR_CAM_Z, 32'h7fffffff);
         end else begin
            csr_write(CSR_CAM_X, $urandom_range(0, 40*U) - 20*U);
            csr_write(CSR_CAM_Y, $urandom_range(0, 40*U) - 20*U);
            csr_write(CSR_CAM_Z, $urandom_range(0, 40*U) - 20*U);
         end
         case (ph % 4)
            0: csr_write(CSR_FAR_LIMIT, 32'h7fffffff);
            1: csr_write(CSR_FAR_LIMIT, $urandom_range(1, 60*U));
            2: csr_write(CSR_FAR_LIMIT, ph == 6 ? 0 : $urandom());
            default: csr_write(CSR_FAR_LIMIT, FAR_RESET);
         endcase
         if (ph == 3) ntri = 1;
         csr_write(CSR_ACTIVE_TRIS, ntri);
         tx_calm = (ph % 3 == 1) || ph == 3;
         for (int s = 0; s < ntri; s++) write_tri(s);
         if (ph == 3) squeeze = 1;
         for (int k = 0; k < (ph == 3 ? 12 : 3); k++) cast_ray(ntri);
         tx_calm = 0;
      end

      while (hit_q.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (n_err == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
